@@ hdl/qcst_pkg.sv @@
// ============================================================================
// qcst_pkg: shared types and constants for the quadrature count speed tracker
// Holds the item structs, the controller/datapath interface structs and the
// sizing constants of the scaled division.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package qcst_pkg;

  // Number of encoder channels with their own tracking state.
  localparam int unsigned CHANNELS    = 2;
  // Counts per millisecond to counts per second.
  localparam int unsigned SPEED_SCALE = 1000;
  // |delta| * 1000 never exceeds 32768 * 1000, which fits in 25 bits.
  localparam int unsigned PROD_W      = 25;
  localparam int unsigned DIV_STEPS   = PROD_W;
  localparam int unsigned CNT_W       = $clog2(DIV_STEPS);

  typedef struct packed {
    logic        channel;
    logic [15:0] counter_value;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic               out_channel;
    logic        [15:0] count_reading;
    logic signed [15:0] step_delta;
    logic signed [31:0] position_total;
    logic        [31:0] sample_time;
    logic signed [15:0] speed_per_second;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch the accepted item
    logic calc;      // read channel state, form delta, total and elapsed time
    logic scale;     // form |delta| * 1000 and seed the divider
    logic div_step;  // one restoring division step
    logic commit;    // update channel state and present the result
  } ctrl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic skip_div;  // first sample, unknown channel or zero elapsed time
    logic div_last;  // the current division step is the final one
  } ctrl_sts_t;

endpackage : qcst_pkg

`default_nettype wire

@@ hdl/qcst_ctrl.sv @@
// ============================================================================
// qcst_ctrl: sequencing state machine
// Steps one item through capture, calculation, scaling, division and commit.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qcst_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               out_free_i,
  input  wire qcst_pkg::ctrl_sts_t sts_i,
  output qcst_pkg::ctrl_cmd_t      cmd_o
);
  import qcst_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CALC  = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = sts_i.skip_div ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule : qcst_ctrl

`default_nettype wire

@@ hdl/qcst_dpath.sv @@
// ============================================================================
// qcst_dpath: per-channel state, delta arithmetic and speed divider
// Holds the channel records and a radix-2 restoring divider for the speed.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module qcst_dpath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire qcst_pkg::in_item_t  in_item_i,
  input  wire qcst_pkg::ctrl_cmd_t cmd_i,
  output qcst_pkg::ctrl_sts_t      sts_o,
  output qcst_pkg::out_item_t      result_o
);
  import qcst_pkg::*;

  // Channel records.
  logic        seen_q       [CHANNELS];
  logic [15:0] prev_count_q [CHANNELS];
  logic [31:0] total_acc_q  [CHANNELS];
  logic [31:0] prev_time_q  [CHANNELS];
  logic [15:0] held_speed_q [CHANNELS];

  // Working registers for the item in flight.
  in_item_t          item_q;
  logic              chan_ok_q;
  logic              first_q;
  logic              dt_zero_q;
  logic [15:0]       delta_q;
  logic [31:0]       total_q;
  logic [31:0]       dt_q;
  logic [31:0]       rem_q;
  logic [PROD_W-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              ch;
  logic              chan_ok;
  logic [15:0]       delta_d;
  logic [31:0]       dt_d;
  logic [16:0]       mag;
  logic [PROD_W-1:0] prod;
  logic [32:0]       trial;
  logic              ge;
  logic [15:0]       speed_sat;
  logic [15:0]       speed_new;

  assign ch      = item_q.channel;
  assign chan_ok = (32'(item_q.channel) < CHANNELS);
  assign delta_d = item_q.counter_value - prev_count_q[ch];
  assign dt_d    = item_q.time_ms - prev_time_q[ch];

  assign mag  = delta_q[15] ? 17'(17'h10000 - {1'b0, delta_q}) : {1'b0, delta_q};
  assign prod = {{(PROD_W-17){1'b0}}, mag} * PROD_W'(SPEED_SCALE);

  assign trial = {rem_q, quo_q[PROD_W-1]};
  assign ge    = (trial >= {1'b0, dt_q});

  // Truncated quotient saturated to the signed 16-bit range.
  always_comb begin
    if (delta_q[15]) begin
      speed_sat = (quo_q > PROD_W'(32768)) ? 16'h8000
                                           : 16'(17'h10000 - quo_q[16:0]);
    end else begin
      speed_sat = (quo_q > PROD_W'(32767)) ? 16'h7FFF : quo_q[15:0];
    end
  end

  assign speed_new = dt_zero_q ? held_speed_q[ch] : speed_sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.calc) begin
      chan_ok_q <= chan_ok;
      first_q   <= !seen_q[ch];
      delta_q   <= delta_d;
      total_q   <= total_acc_q[ch] + {{16{delta_d[15]}}, delta_d};
      dt_q      <= dt_d;
      dt_zero_q <= (dt_d == 32'd0);
    end
    if (cmd_i.scale) begin
      quo_q <= prod;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 32'(trial - {1'b0, dt_q}) : trial[31:0];
      quo_q <= {quo_q[PROD_W-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        seen_q[i]       <= 1'b0;
        prev_count_q[i] <= '0;
        total_acc_q[i]  <= '0;
        prev_time_q[i]  <= '0;
        held_speed_q[i] <= '0;
      end
    end else if (cmd_i.commit && chan_ok_q) begin
      seen_q[ch]       <= 1'b1;
      prev_count_q[ch] <= item_q.counter_value;
      prev_time_q[ch]  <= item_q.time_ms;
      if (first_q) begin
        total_acc_q[ch]  <= '0;
        held_speed_q[ch] <= '0;
      end else begin
        total_acc_q[ch]  <= total_q;
        held_speed_q[ch] <= speed_new;
      end
    end
  end

  assign sts_o.skip_div = first_q || !chan_ok_q || dt_zero_q;
  assign sts_o.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    result_o.out_channel      = item_q.channel;
    result_o.count_reading    = item_q.counter_value;
    result_o.sample_time      = item_q.time_ms;
    result_o.step_delta       = '0;
    result_o.position_total   = '0;
    result_o.speed_per_second = '0;
    if (chan_ok_q && !first_q) begin
      result_o.step_delta       = delta_q;
      result_o.position_total   = total_q;
      result_o.speed_per_second = speed_new;
    end
  end

endmodule : qcst_dpath

`default_nettype wire

@@ hdl/quadrature_count_speed_tracker.sv @@
// ============================================================================
// quadrature_count_speed_tracker: encoder position and speed per channel
// Tracks wrapped counter changes, a running position total and a saturated
// counts-per-second speed for each encoder channel.
// ============================================================================
//
//  Channel   Direction  Handshake             Payload
//  in        sink       in_valid_i/in_stall_o  qcst_pkg::in_item_t
//  out       source     out_valid_o/out_stall_i qcst_pkg::out_item_t
//
// An item with elapsed time goes through acceptance, calculation, scaling,
// 25 divider steps and commit on its way to the result register.
// The restoring divider yields one quotient bit per cycle.
// A first sample, an unknown channel or zero elapsed time skips the divider.
// One item is in work at a time.
// Reset clears every channel record, so the next sample of each channel is
// treated as its first. A stalled result waits in the output register while
// the next item is taken in; commit waits until that register is free.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_count_speed_tracker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire qcst_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output qcst_pkg::out_item_t      out_item_o
);
  import qcst_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  out_item_t result;
  logic      out_free;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;

  // The output register is free when empty or being emptied this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  qcst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  qcst_dpath u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // The result is captured as the channel record is updated.
  always_ff @(posedge clk_i) begin
    if (cmd.commit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A commit never overwrites a result that is still waiting.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> out_free)
    else $error("commit while the output register holds a stalled item");

  // A commit always leaves a valid result behind.
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_q)
    else $error("result not presented after commit");

  // An accepted item closes the input until its result is committed.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && !cmd.commit))
    else $error("input left open after acceptance");

endmodule : quadrature_count_speed_tracker

`default_nettype wire

@@ tb/sv/tb_quadrature_count_speed_tracker.sv @@
// ============================================================================
// tb_quadrature_count_speed_tracker: self-checking bench for the speed tracker
// Samples are driven over the valid/stall input channel and every snapshot
// leaving the output channel is compared with a typed-in snapshot or an
// in-bench prediction of the per-channel delta, position total and
// saturated speed. A directed table opens the run. It is followed by phases
// of shaped random samples under varying sender gaps and receiver stalls.
// ============================================================================
`timescale 1ns / 1ps

module tb_quadrature_count_speed_tracker;
  import qcst_pkg::*;

  // Sender and receiver behaviour for the current phase.
  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_RUNS} rx_mode_e;
  typedef enum logic {TX_STREAM, TX_BURSTS} tx_mode_e;

  // One row of the directed table. Where has_snap is set, snap is the result
  // read straight off the behaviour. Otherwise the prediction is used.
  typedef struct packed {
    in_item_t  stim;
    logic      has_snap;
    out_item_t snap;
  } dir_row_t;

  localparam int unsigned N_DIRECTED = 20;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 350;

  localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
    // First sample of each channel, at the extremes of count and time.
    '{'{1'b0, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
      '{1'b0, 16'hFFFF, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 16'h0000}},
    '{'{1'b1, 16'h0000, 32'h0000_0000}, 1'b1,
      '{1'b1, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 16'h0000}},
    // Largest positive delta over one millisecond across the time wrap.
    '{'{1'b0, 16'h7FFE, 32'h0000_0000}, 1'b1,
      '{1'b0, 16'h7FFE, 16'h7FFF, 32'h0000_7FFF, 32'h0000_0000, 16'h7FFF}},
    // No time has passed, so the speed is held.
    '{'{1'b0, 16'h7FFE, 32'h0000_0000}, 1'b1,
      '{1'b0, 16'h7FFE, 16'h0000, 32'h0000_7FFF, 32'h0000_0000, 16'h7FFF}},
    // Most negative delta over one second gives exactly the lowest speed.
    '{'{1'b0, 16'hFFFE, 32'd1000}, 1'b1,
      '{1'b0, 16'hFFFE, 16'h8000, 32'hFFFF_FFFF, 32'd1000, 16'h8000}},
    '{'{1'b0, 16'hFFFE, 32'd1000}, 1'b1,
      '{1'b0, 16'hFFFE, 16'h0000, 32'hFFFF_FFFF, 32'd1000, 16'h8000}},
    // Longest possible elapsed time.
    '{'{1'b1, 16'h0001, 32'hFFFF_FFFF}, 1'b1,
      '{1'b1, 16'h0001, 16'h0001, 32'h0000_0001, 32'hFFFF_FFFF, 16'h0000}},
    // Negative saturation over one millisecond.
    '{'{1'b1, 16'h8001, 32'h0000_0000}, 1'b1,
      '{1'b1, 16'h8001, 16'h8000, 32'hFFFF_8001, 32'h0000_0000, 16'h8000}},
    // Truncation toward zero in both directions.
    '{'{1'b1, 16'h8000, 32'd3}, 1'b0, '0},
    '{'{1'b1, 16'h8001, 32'd6}, 1'b0, '0},
    '{'{1'b0, 16'h0000, 32'd2000}, 1'b0, '0},
    '{'{1'b0, 16'h0021, 32'd2999}, 1'b0, '0},
    '{'{1'b0, 16'h001C, 32'd3000}, 1'b0, '0},
    // Just beyond the positive and negative limits, then just inside.
    '{'{1'b1, 16'h8022, 32'd7}, 1'b0, '0},
    '{'{1'b1, 16'h8001, 32'd8}, 1'b0, '0},
    '{'{1'b1, 16'h8021, 32'd9}, 1'b0, '0},
    '{'{1'b0, 16'h001C, 32'h7FFF_FFFF}, 1'b0, '0},
    '{'{1'b0, 16'hAAAA, 32'h8000_0000}, 1'b0, '0},
    '{'{1'b1, 16'h5555, 32'hAAAA_AAAA}, 1'b0, '0},
    '{'{1'b0, 16'h5555, 32'h5555_5555}, 1'b0, '0}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Per-channel copy of the tracking state, advanced on every accepted item.
  logic        primed     [CHANNELS];
  logic [15:0] last_count [CHANNELS];
  logic [31:0] pos_total  [CHANNELS];
  logic [31:0] last_time  [CHANNELS];
  logic [15:0] last_speed [CHANNELS];

  out_item_t pending[$];
  int        mismatches = 0;

  tx_mode_e    tx_mode = TX_STREAM;
  rx_mode_e    rx_mode = RX_FREE;
  int unsigned burst_left = 0;
  int unsigned run_left = 0;
  int unsigned hold_left = 0;
  int unsigned hold_token = 0;
  int unsigned hold_seen = 0;

  quadrature_count_speed_tracker u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #5 clk = ~clk;

  // Signed delta * 1000 / elapsed, truncated toward zero, clamped to 16 bits.
  // Elapsed time must be non-zero here.
  function automatic logic [15:0] scaled_speed(logic [15:0] delta, logic [31:0] dt);
    logic [31:0] mag;
    logic [31:0] quot;
    mag  = delta[15] ? (32'h0001_0000 - {16'h0000, delta}) : {16'h0000, delta};
    quot = (mag * SPEED_SCALE) / dt;
    if (delta[15]) begin
      if (quot > 32'd32768) quot = 32'd32768;
      quot = 32'h0001_0000 - quot;
    end else if (quot > 32'd32767) begin
      quot = 32'd32767;
    end
    return quot[15:0];
  endfunction

  // Advances the channel state by one sample and returns its snapshot.
  function automatic out_item_t track_sample(in_item_t it);
    out_item_t   snap;
    logic [15:0] delta;
    logic [31:0] dt;
    snap.out_channel      = it.channel;
    snap.count_reading    = it.counter_value;
    snap.sample_time      = it.time_ms;
    snap.step_delta       = '0;
    snap.position_total   = '0;
    snap.speed_per_second = '0;
    if (!primed[it.channel]) begin
      // The first sample of a channel only seeds its record.
      primed[it.channel]     = 1'b1;
      last_count[it.channel] = it.counter_value;
      pos_total[it.channel]  = '0;
      last_time[it.channel]  = it.time_ms;
      last_speed[it.channel] = '0;
    end else begin
      delta = it.counter_value - last_count[it.channel];
      pos_total[it.channel] = pos_total[it.channel] + {{16{delta[15]}}, delta};
      dt = it.time_ms - last_time[it.channel];
      // With no elapsed time the previous speed stands.
      if (dt != 32'd0) last_speed[it.channel] = scaled_speed(delta, dt);
      last_count[it.channel] = it.counter_value;
      last_time[it.channel]  = it.time_ms;
      snap.step_delta        = delta;
      snap.position_total    = pos_total[it.channel];
      snap.speed_per_second  = last_speed[it.channel];
    end
    return snap;
  endfunction

  // Offers one item and returns at the edge that accepted it. In burst mode
  // the line may first go idle for a random gap. The snapshot to expect is
  // queued on acceptance, either the typed-in one or the predicted one.
  task automatic offer(in_item_t it, logic has_snap, out_item_t snap);
    out_item_t predicted;
    if (tx_mode == TX_BURSTS) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = track_sample(it);
    pending.push_back(has_snap ? snap : predicted);
  endtask

  // Drops the line and waits for every outstanding snapshot to come back.
  task automatic pause_line();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic field_check(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_snapshot(out_item_t got);
    out_item_t want;
    if (pending.size() == 0) begin
      $error("result item arrived with no snapshot outstanding: %h", got);
      mismatches++;
      return;
    end
    want = pending.pop_front();
    field_check("out_channel", want.out_channel, got.out_channel);
    field_check("count_reading", want.count_reading, got.count_reading);
    field_check("step_delta", $signed(want.step_delta), $signed(got.step_delta));
    field_check("position_total", $signed(want.position_total),
                $signed(got.position_total));
    field_check("sample_time", want.sample_time, got.sample_time);
    field_check("speed_per_second", $signed(want.speed_per_second),
                $signed(got.speed_per_second));
  endtask

  // Output monitor: an item leaves at an edge where valid is high and the
  // bench is not stalling.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_snapshot(out_item);
  end

  // Receiver. A bump of hold_token starts a long hold-off, counted here, so
  // that the output register and then the input channel back up. Otherwise
  // the stall follows the mode of the phase: never, a random one cycle in
  // three, or runs of random length, each of them stalled or free at random.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FREE: begin
          out_stall <= 1'b0;
        end
        RX_RANDOM: begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end
        default: begin
          if (run_left == 0) begin
            if ($urandom_range(0, 1) == 1) begin
              out_stall <= 1'b1;
              run_left  <= $urandom_range(1, 6);
            end else begin
              out_stall <= 1'b0;
              run_left  <= $urandom_range(1, 30);
            end
          end else begin
            run_left <= run_left - 1;
          end
        end
      endcase
    end
  end

  initial begin : stimulus
    in_item_t    item;
    logic [15:0] step;
    logic [31:0] gap_ms;

    for (int c = 0; c < CHANNELS; c++) begin
      primed[c]     = 1'b0;
      last_count[c] = '0;
      pos_total[c]  = '0;
      last_time[c]  = '0;
      last_speed[c] = '0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with the receiver stalling at random.
    tx_mode = TX_STREAM;
    rx_mode = RX_RANDOM;
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer(DIRECTED[i].stim, DIRECTED[i].has_snap, DIRECTED[i].snap);
    end
    pause_line();

    // Random phases. Most items are well-formed follow-ups to the previous
    // sample of their channel, with step and elapsed time drawn from several
    // scales. One in ten is fully random noise.
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin tx_mode = TX_STREAM; rx_mode = RX_FREE;   end
        1: begin tx_mode = TX_STREAM; rx_mode = RX_RANDOM; hold_token++; end
        2: begin tx_mode = TX_BURSTS; rx_mode = RX_RUNS;   end
        3: begin tx_mode = TX_STREAM; rx_mode = RX_RUNS;   end
        default: begin tx_mode = TX_BURSTS; rx_mode = RX_FREE; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // The hold-off phase streams for a while so the block fills up.
        if (phase == 1 && n == 12) tx_mode = TX_BURSTS;
        item.channel = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0) begin
          item.counter_value = 16'($urandom);
          item.time_ms       = $urandom;
        end else begin
          case ($urandom_range(0, 3))
            0:       step = 16'($urandom_range(0, 40));
            1:       step = 16'($urandom_range(0, 2000));
            2:       step = 16'($urandom_range(32000, 32768));
            default: step = 16'($urandom);
          endcase
          if ($urandom_range(0, 1) == 1) step = -step;
          case ($urandom_range(0, 4))
            0:       gap_ms = 32'd0;
            1:       gap_ms = $urandom_range(1, 4);
            2:       gap_ms = $urandom_range(1, 100);
            3:       gap_ms = $urandom_range(1, 60000);
            default: gap_ms = $urandom;
          endcase
          item.counter_value = last_count[item.channel] + step;
          item.time_ms       = last_time[item.channel] + gap_ms;
        end
        offer(item, 1'b0, '0);
      end
      pause_line();
    end

    // Let any stray result show itself before the verdict.
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS quadrature_count_speed_tracker");
    end else begin
      $display("FAIL quadrature_count_speed_tracker");
    end
    $finish;
  end

  // Watchdog, set well beyond the slowest correct run.
  initial begin : watchdog
    #(50_000_000);
    $display("FAIL quadrature_count_speed_tracker");
    $finish;
  end

endmodule
